>>> src/tpe_pkg.sv
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared constants, opcodes and command types of the taint propagation engine.
// ----------------------------------------------------------------------------
package tpe_pkg;

    localparam int ADDR_BITS_DEF = 12;
    localparam int NUM_REGS_DEF  = 16;
    localparam int MAX_SIZE_DEF  = 16;

    localparam int OPC_W       = 4;
    localparam int REG_W       = 4;
    localparam int SIZE_IN_W   = 5;
    localparam int OFFS_W      = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OPC_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OPC_W-1:0] OP_REG_COPY = 4'd1;
    localparam logic [OPC_W-1:0] OP_REG_MEM  = 4'd2;
    localparam logic [OPC_W-1:0] OP_REG_CLR  = 4'd3;
    localparam logic [OPC_W-1:0] OP_MEM_REG  = 4'd4;
    localparam logic [OPC_W-1:0] OP_MEM_CLR  = 4'd5;
    localparam logic [OPC_W-1:0] OP_REG_OR   = 4'd6;
    localparam logic [OPC_W-1:0] OP_REG_SET  = 4'd7;
    localparam logic [OPC_W-1:0] OP_MEM_SET  = 4'd8;

    typedef enum logic [2:0] {
        K_NOP,
        K_REG_CONST,
        K_REG_COPY,
        K_REG_OR,
        K_REG_MEM,
        K_MEM_REG,
        K_MEM_CONST
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             bad;
        logic             const_val;
        logic [REG_W-1:0] dest_reg;
        logic [REG_W-1:0] src_a;
        logic [REG_W-1:0] src_b;
    } t_cmd;

endpackage

>>> src/tpe_ram.sv
// ----------------------------------------------------------------------------
// tpe_ram
// Generic single-port RAM, one read or write address per cycle, registered read.
// ----------------------------------------------------------------------------
module tpe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tpe_front.sv
// ----------------------------------------------------------------------------
// tpe_front
// Input beat acceptance and opcode classification into queue commands.
// ----------------------------------------------------------------------------
module tpe_front #(
    parameter int ADDR_BITS = tpe_pkg::ADDR_BITS_DEF,
    parameter int MAX_SIZE  = tpe_pkg::MAX_SIZE_DEF
) (
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tpe_pkg::OPC_W-1:0]           i_opcode,
    input  logic [tpe_pkg::REG_W-1:0]           i_dest_reg,
    input  logic [tpe_pkg::REG_W-1:0]           i_src_reg,
    input  logic [tpe_pkg::REG_W-1:0]           i_src_reg_b,
    input  logic [ADDR_BITS-1:0]                i_mem_addr,
    input  logic [tpe_pkg::SIZE_IN_W-1:0]       i_mem_size,
    input  logic signed [tpe_pkg::OFFS_W-1:0]   i_addr_offset,
    input  logic                                i_q_full,
    input  logic                                i_clr_done,
    output logic                                o_push,
    output tpe_pkg::t_cmd                       o_cmd,
    output logic [ADDR_BITS-1:0]                o_addr,
    output logic [$clog2(MAX_SIZE+1)-1:0]       o_size
);
    import tpe_pkg::*;

    localparam int SIZE_W = $clog2(MAX_SIZE + 1);
    localparam int CMP_W  = (SIZE_W > SIZE_IN_W) ? SIZE_W : SIZE_IN_W;

    logic [CMP_W-1:0] size_ext;

    assign o_ready  = !i_q_full && i_clr_done;
    assign o_push   = i_valid && o_ready;
    assign size_ext = CMP_W'(i_mem_size);
    assign o_size   = (size_ext > CMP_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : SIZE_W'(size_ext);

    always_comb begin
        o_cmd.kind      = K_NOP;
        o_cmd.bad       = 1'b0;
        o_cmd.const_val = 1'b0;
        o_cmd.dest_reg  = i_dest_reg;
        o_cmd.src_a     = i_src_reg;
        o_cmd.src_b     = i_src_reg_b;
        o_addr          = i_mem_addr;
        unique case (i_opcode)
            OP_NOP: begin
                o_cmd.kind = K_NOP;
            end
            OP_REG_COPY: begin
                o_cmd.kind = K_REG_COPY;
            end
            OP_REG_MEM: begin
                o_cmd.kind = K_REG_MEM;
            end
            OP_REG_CLR: begin
                o_cmd.kind = K_REG_CONST;
            end
            OP_MEM_REG: begin
                o_cmd.kind  = K_MEM_REG;
                o_cmd.src_a = i_dest_reg;
                o_addr      = i_mem_addr + ADDR_BITS'(i_addr_offset);
            end
            OP_MEM_CLR: begin
                o_cmd.kind = K_MEM_CONST;
            end
            OP_REG_OR: begin
                o_cmd.kind = K_REG_OR;
            end
            OP_REG_SET: begin
                o_cmd.kind      = K_REG_CONST;
                o_cmd.const_val = 1'b1;
            end
            OP_MEM_SET: begin
                o_cmd.kind      = K_MEM_CONST;
                o_cmd.const_val = 1'b1;
            end
            default: begin
                o_cmd.bad = 1'b1;
            end
        endcase
    end

endmodule

>>> src/tpe_queue.sv
// ----------------------------------------------------------------------------
// tpe_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module tpe_queue #(
    parameter int ADDR_BITS = tpe_pkg::ADDR_BITS_DEF,
    parameter int MAX_SIZE  = tpe_pkg::MAX_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  tpe_pkg::t_cmd                 i_cmd,
    input  logic [ADDR_BITS-1:0]          i_addr,
    input  logic [$clog2(MAX_SIZE+1)-1:0] i_size,
    output logic                          o_full,
    output logic                          o_valid,
    input  logic                          i_pop,
    output tpe_pkg::t_cmd                 o_cmd,
    output logic [ADDR_BITS-1:0]          o_addr,
    output logic [$clog2(MAX_SIZE+1)-1:0] o_size
);
    import tpe_pkg::*;

    localparam int SIZE_W = $clog2(MAX_SIZE + 1);
    localparam int DEPTH  = QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    t_cmd               r_cmd  [DEPTH];
    logic [ADDR_BITS-1:0] r_addr [DEPTH];
    logic [SIZE_W-1:0]  r_size [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_cmd[r_rd];
    assign o_addr  = r_addr[r_rd];
    assign o_size  = r_size[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wr]  <= i_cmd;
            r_addr[r_wr] <= i_addr;
            r_size[r_wr] <= i_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> src/tpe_back.sv
// ----------------------------------------------------------------------------
// tpe_back
// Command execution: register taint flops, shadow RAM walk, clearing pass
// after reset and the result output register.
// ----------------------------------------------------------------------------
module tpe_back #(
    parameter int ADDR_BITS = tpe_pkg::ADDR_BITS_DEF,
    parameter int NUM_REGS  = tpe_pkg::NUM_REGS_DEF,
    parameter int MAX_SIZE  = tpe_pkg::MAX_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  tpe_pkg::t_cmd                 i_cmd,
    input  logic [ADDR_BITS-1:0]          i_addr,
    input  logic [$clog2(MAX_SIZE+1)-1:0] i_size,
    output logic                          o_clr_done,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_written_taint,
    output logic                          o_bad_opcode
);
    import tpe_pkg::*;

    localparam int SIZE_W    = $clog2(MAX_SIZE + 1);
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int RCMP_RAW  = $clog2(NUM_REGS + 1);
    localparam int RCMP_W    = (RCMP_RAW > REG_W) ? RCMP_RAW : REG_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_RDA   = 6'b000100,
        S_RDB   = 6'b001000,
        S_MEM   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    t_cmd                 r_cmd;
    logic [ADDR_BITS-1:0] r_addr;
    logic [SIZE_W-1:0]    r_size;
    logic [SIZE_W-1:0]    r_cnt;
    logic                 r_w;
    logic                 r_pend;
    logic [ADDR_BITS-1:0] r_clr_cnt;
    logic [NUM_REGS-1:0]  r_regs;
    logic                 r_out_valid;
    logic                 r_out_w;
    logic                 r_out_bad;

    logic [REG_W-1:0]     rd_idx;
    logic                 rd_val;
    logic                 dest_ok;
    logic                 writes_reg;
    logic                 walk_done;
    logic                 out_free;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_addr;
    logic                 ram_wdata;
    logic                 ram_rdata;

    tpe_ram #(
        .WIDTH (1),
        .DEPTH (1 << ADDR_BITS)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_idx     = (r_state == S_RDB) ? r_cmd.src_b : r_cmd.src_a;
    assign rd_val     = (RCMP_W'(rd_idx) < RCMP_W'(NUM_REGS)) ?
                        r_regs[REG_IDX_W'(rd_idx)] : 1'b0;
    assign dest_ok    = (RCMP_W'(r_cmd.dest_reg) < RCMP_W'(NUM_REGS));
    assign writes_reg = (r_cmd.kind == K_REG_CONST) || (r_cmd.kind == K_REG_COPY) ||
                        (r_cmd.kind == K_REG_OR) || (r_cmd.kind == K_REG_MEM);
    assign walk_done  = (r_cnt == r_size);
    assign out_free   = !r_out_valid || i_ready;
    assign ram_we     = (r_state == S_CLEAR) ||
                        ((r_state == S_MEM) && !walk_done && (r_cmd.kind != K_REG_MEM));
    assign ram_addr   = (r_state == S_CLEAR) ? r_clr_cnt : r_addr;
    assign ram_wdata  = (r_state == S_CLEAR) ? 1'b0 : r_w;

    assign o_q_pop         = (r_state == S_IDLE) && i_q_valid;
    assign o_clr_done      = (r_state != S_CLEAR);
    assign o_valid         = r_out_valid;
    assign o_written_taint = r_out_w;
    assign o_bad_opcode    = r_out_bad;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == {ADDR_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_cmd.kind) inside
                        K_REG_COPY, K_REG_OR, K_MEM_REG: n_state = S_RDA;
                        K_REG_MEM, K_MEM_CONST:          n_state = S_MEM;
                        default:                         n_state = S_DONE;
                    endcase
                end
            end
            S_RDA: begin
                if (r_cmd.kind == K_REG_OR) begin
                    n_state = S_RDB;
                end else if (r_cmd.kind == K_MEM_REG) begin
                    n_state = S_MEM;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RDB: begin
                n_state = S_DONE;
            end
            S_MEM: begin
                if (walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_regs      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_MEM) && !walk_done && (r_cmd.kind == K_REG_MEM);
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + ADDR_BITS'(1);
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                if (writes_reg && dest_ok) begin
                    r_regs[REG_IDX_W'(r_cmd.dest_reg)] <= r_w;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd  <= i_cmd;
            r_addr <= i_addr;
            r_size <= i_size;
            r_cnt  <= '0;
            r_w    <= i_cmd.const_val;
        end else begin
            if (r_state == S_RDA) begin
                r_w <= rd_val;
            end
            if (r_state == S_RDB) begin
                r_w <= r_w | rd_val;
            end
            if (r_pend) begin
                r_w <= r_w | ram_rdata;
            end
            if ((r_state == S_MEM) && !walk_done) begin
                r_addr <= r_addr + ADDR_BITS'(1);
                r_cnt  <= r_cnt + SIZE_W'(1);
            end
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_w   <= r_w;
            r_out_bad <= r_cmd.bad;
        end
    end

endmodule

>>> src/taint_propagation_engine.sv
// ----------------------------------------------------------------------------
// taint_propagation_engine
// Shadow taint tracker: one taint bit per register and per shadow byte,
// updated by opcoded copy, OR, clear, set and range operations.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  command  | in        | i_valid / o_ready  | opcode, regs, address, size, offset
//  result   | out       | o_valid / i_ready  | written_taint, bad_opcode
//
//  Back end: nop, clear, set and bad opcodes go idle to done; copy reads in
//  S_RDA, OR in S_RDA and S_RDB; range ops walk in S_MEM (range-from-register
//  after S_RDA); the range walk goes one shadow byte per cycle
//  through the single-port shadow RAM. A two-entry queue lets the front
//  take beats while the back works. After reset a clearing pass zeroes
//  the shadow RAM with o_ready low.
// ----------------------------------------------------------------------------
module taint_propagation_engine #(
    parameter int ADDR_BITS = tpe_pkg::ADDR_BITS_DEF,
    parameter int NUM_REGS  = tpe_pkg::NUM_REGS_DEF,
    parameter int MAX_SIZE  = tpe_pkg::MAX_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tpe_pkg::OPC_W-1:0]         i_opcode,
    input  logic [tpe_pkg::REG_W-1:0]         i_dest_reg,
    input  logic [tpe_pkg::REG_W-1:0]         i_src_reg,
    input  logic [tpe_pkg::REG_W-1:0]         i_src_reg_b,
    input  logic [ADDR_BITS-1:0]              i_mem_addr,
    input  logic [tpe_pkg::SIZE_IN_W-1:0]     i_mem_size,
    input  logic signed [tpe_pkg::OFFS_W-1:0] i_addr_offset,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_written_taint,
    output logic                              o_bad_opcode
);
    import tpe_pkg::*;

    localparam int SIZE_W = $clog2(MAX_SIZE + 1);

    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic                 push;
    logic                 clr_done;
    t_cmd                 f_cmd;
    logic [ADDR_BITS-1:0] f_addr;
    logic [SIZE_W-1:0]    f_size;
    t_cmd                 q_cmd;
    logic [ADDR_BITS-1:0] q_addr;
    logic [SIZE_W-1:0]    q_size;

    tpe_front #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_SIZE  (MAX_SIZE)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_dest_reg    (i_dest_reg),
        .i_src_reg     (i_src_reg),
        .i_src_reg_b   (i_src_reg_b),
        .i_mem_addr    (i_mem_addr),
        .i_mem_size    (i_mem_size),
        .i_addr_offset (i_addr_offset),
        .i_q_full      (q_full),
        .i_clr_done    (clr_done),
        .o_push        (push),
        .o_cmd         (f_cmd),
        .o_addr        (f_addr),
        .o_size        (f_size)
    );

    tpe_queue #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_SIZE  (MAX_SIZE)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_addr  (f_addr),
        .i_size  (f_size),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr),
        .o_size  (q_size)
    );

    tpe_back #(
        .ADDR_BITS (ADDR_BITS),
        .NUM_REGS  (NUM_REGS),
        .MAX_SIZE  (MAX_SIZE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_cmd           (q_cmd),
        .i_addr          (q_addr),
        .i_size          (q_size),
        .o_clr_done      (clr_done),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_written_taint (o_written_taint),
        .o_bad_opcode    (o_bad_opcode)
    );

endmodule

>>> bench/taint_propagation_engine_tb.sv
// ----------------------------------------------------------------------------
// taint_propagation_engine_tb
// Self-checking bench for the shadow taint tracker. Commands go in from a
// queue through a bursty driver. A shadow copy of the register and byte taint
// works out the expected beat for every accepted command. The monitor checks
// each result beat against it while the receiver stalls in patterns and holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module taint_propagation_engine_tb;

    import tpe_pkg::*;

    localparam int ADDR_W      = ADDR_BITS_DEF;
    localparam int N_REGS      = NUM_REGS_DEF;
    localparam int SPAN_MAX    = MAX_SIZE_DEF;
    localparam int N_RANDOM    = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 64;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;

    localparam logic [OPC_W-1:0]         OP_TOP     = '1;
    localparam logic [ADDR_W-1:0]        HOT_BASE   = 12'h340;
    localparam logic [ADDR_W-1:0]        ADDR_TOP   = '1;
    localparam logic signed [OFFS_W-1:0] PUSH_OFFS  = OFFS_W'(-4);
    localparam logic signed [OFFS_W-1:0] OFFS_MIN   = OFFS_W'(-8);
    localparam logic signed [OFFS_W-1:0] OFFS_MAX   = OFFS_W'(7);
    localparam logic [SIZE_IN_W-1:0]     SIZE_TOP   = '1;
    localparam logic [REG_W-1:0]         REG_TOP    = '1;

    typedef struct {
        logic [OPC_W-1:0]         opcode;
        logic [REG_W-1:0]         dest;
        logic [REG_W-1:0]         src_a;
        logic [REG_W-1:0]         src_b;
        logic [ADDR_W-1:0]        addr;
        logic [SIZE_IN_W-1:0]     size;
        logic signed [OFFS_W-1:0] offs;
    } taint_op_t;

    typedef struct packed {
        logic taint;
        logic bad;
    } taint_result_t;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [OPC_W-1:0]          i_opcode      = OP_NOP;
    logic [REG_W-1:0]          i_dest_reg    = '0;
    logic [REG_W-1:0]          i_src_reg     = '0;
    logic [REG_W-1:0]          i_src_reg_b   = '0;
    logic [ADDR_W-1:0]         i_mem_addr    = '0;
    logic [SIZE_IN_W-1:0]      i_mem_size    = '0;
    logic signed [OFFS_W-1:0]  i_addr_offset = '0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic                      o_written_taint;
    logic                      o_bad_opcode;

    taint_op_t     pending_ops[$];
    taint_result_t expected_results[$];
    logic          reg_shadow[N_REGS];
    logic          mem_shadow[1 << ADDR_W];

    int  n_total     = 0;
    int  n_accepted  = 0;
    int  n_errors    = 0;
    int  n_cycles    = 0;
    logic cmd_taken  = 1'b0;

    int  burst_left  = 0;
    int  gap_left    = 0;
    int  stall_mode  = 0;
    int  stall_left  = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;

    taint_propagation_engine u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_dest_reg      (i_dest_reg),
        .i_src_reg       (i_src_reg),
        .i_src_reg_b     (i_src_reg_b),
        .i_mem_addr      (i_mem_addr),
        .i_mem_size      (i_mem_size),
        .i_addr_offset   (i_addr_offset),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_written_taint (o_written_taint),
        .o_bad_opcode    (o_bad_opcode)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic taint_op_t pack_op(input logic [OPC_W-1:0] opcode,
                                          input logic [REG_W-1:0] dest,
                                          input logic [REG_W-1:0] src_a,
                                          input logic [REG_W-1:0] src_b,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [SIZE_IN_W-1:0] size,
                                          input logic signed [OFFS_W-1:0] offs);
        taint_op_t op;
        op = '{opcode, dest, src_a, src_b, addr, size, offs};
        return op;
    endfunction

    function automatic taint_op_t random_op();
        taint_op_t   op;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            op.opcode = OP_NOP;
        end else if (pick < 10) begin
            op.opcode = OPC_W'($urandom_range(OP_MEM_SET + 1, OP_TOP));
        end else begin
            op.opcode = OPC_W'($urandom_range(OP_REG_COPY, OP_MEM_SET));
        end
        op.dest  = REG_W'($urandom());
        op.src_a = REG_W'($urandom());
        op.src_b = REG_W'($urandom());
        case ($urandom_range(0, 4))
            0, 1, 2: op.addr = HOT_BASE + ADDR_W'($urandom_range(0, 63));
            3:       op.addr = ADDR_W'($urandom_range(0, 31) - 16);
            default: op.addr = ADDR_W'($urandom());
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            op.size = SIZE_IN_W'($urandom_range(0, 8));
        end else if (pick < 90) begin
            op.size = SIZE_IN_W'($urandom_range(9, SPAN_MAX));
        end else begin
            op.size = SIZE_IN_W'($urandom_range(SPAN_MAX + 1, SIZE_TOP));
        end
        op.offs = ($urandom_range(0, 4) == 0) ? PUSH_OFFS : OFFS_W'($urandom());
        return op;
    endfunction

    // shadow copy of the tracker; returns the beat the block should send
    function automatic taint_result_t apply_taint_op(input taint_op_t op);
        taint_result_t     res;
        logic [ADDR_W-1:0] base;
        int unsigned       span;
        bit                fill;
        res  = '0;
        fill = 1'b0;
        base = op.addr;
        span = (op.size > SPAN_MAX) ? SPAN_MAX : op.size;
        case (op.opcode)
            OP_NOP: res = '0;
            OP_REG_COPY: begin
                res.taint = reg_shadow[op.src_a];
                reg_shadow[op.dest] = res.taint;
            end
            OP_REG_MEM: begin
                for (int unsigned i = 0; i < span; i++) begin
                    res.taint |= mem_shadow[ADDR_W'(op.addr + i)];
                end
                reg_shadow[op.dest] = res.taint;
            end
            OP_REG_CLR: begin
                res.taint = 1'b0;
                reg_shadow[op.dest] = 1'b0;
            end
            OP_MEM_REG: begin
                res.taint = reg_shadow[op.dest];
                base = op.addr + {{(ADDR_W - OFFS_W){op.offs[OFFS_W-1]}}, op.offs};
                fill = 1'b1;
            end
            OP_MEM_CLR: begin
                res.taint = 1'b0;
                fill = 1'b1;
            end
            OP_REG_OR: begin
                res.taint = reg_shadow[op.src_a] | reg_shadow[op.src_b];
                reg_shadow[op.dest] = res.taint;
            end
            OP_REG_SET: begin
                res.taint = 1'b1;
                reg_shadow[op.dest] = 1'b1;
            end
            OP_MEM_SET: begin
                res.taint = 1'b1;
                fill = 1'b1;
            end
            default: res.bad = 1'b1;
        endcase
        if (fill) begin
            for (int unsigned i = 0; i < span; i++) begin
                mem_shadow[ADDR_W'(base + i)] = res.taint;
            end
        end
        return res;
    endfunction

    // driver: bursts of beats with random gaps
    always @(negedge i_clk) begin : drive_cmd
        taint_op_t op;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !cmd_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                op = pending_ops.pop_front();
                i_opcode      <= op.opcode;
                i_dest_reg    <= op.dest;
                i_src_reg     <= op.src_a;
                i_src_reg_b   <= op.src_b;
                i_mem_addr    <= op.addr;
                i_mem_size    <= op.size;
                i_addr_offset <= op.offs;
                i_valid       <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: stall patterns, plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end
            stall_left--;
            case (stall_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 3) != 0);
                2:       i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= (stall_left % 3 != 0);
            endcase
        end
    end

    // monitor: predict on command beats, check on result beats
    always @(posedge i_clk) begin : watch_beats
        taint_op_t     op;
        taint_result_t want;
        if (!i_rst_n) begin
            reg_shadow = '{default: 1'b0};
            mem_shadow = '{default: 1'b0};
            expected_results.delete();
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                op = pack_op(i_opcode, i_dest_reg, i_src_reg, i_src_reg_b,
                             i_mem_addr, i_mem_size, i_addr_offset);
                expected_results.push_back(apply_taint_op(op));
                n_accepted++;
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing pending (taint %0b bad %0b)",
                             $time, o_written_taint, o_bad_opcode);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_written_taint !== want.taint) begin
                        $display("%0t: written_taint expected %0b got %0b",
                                 $time, want.taint, o_written_taint);
                        n_errors++;
                    end
                    if (o_bad_opcode !== want.bad) begin
                        $display("%0t: bad_opcode expected %0b got %0b",
                                 $time, want.bad, o_bad_opcode);
                        n_errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        taint_op_t        op;
        logic [REG_W-1:0] ra;
        logic [REG_W-1:0] rb;
        int unsigned      span;

        // directed: cleared state, register ops, wrap, saturation, zero size
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd3, '0, '0, '0, SIZE_TOP, '0));
        pending_ops.push_back(pack_op(OP_REG_SET, REG_TOP, '0, '0, '0, '0, '0));
        pending_ops.push_back(pack_op(OP_REG_COPY, '0, REG_TOP, '0, '0, '0, '0));
        pending_ops.push_back(pack_op(OP_REG_OR, 4'd2, '0, 4'd1, '0, '0, '0));
        pending_ops.push_back(pack_op(OP_REG_OR, 4'd5, 4'd1, 4'd4, '0, '0, '0));
        pending_ops.push_back(pack_op(OP_REG_CLR, REG_TOP, '0, '0, '0, '0, '0));
        pending_ops.push_back(pack_op(OP_MEM_SET, '0, '0, '0, 12'hFFC, SIZE_TOP, '0));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd6, '0, '0, 12'h00B, 5'd1, '0));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd7, '0, '0, 12'h00C, 5'd1, '0));
        pending_ops.push_back(pack_op(OP_MEM_CLR, '0, '0, '0, ADDR_TOP, 5'd1, '0));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd8, '0, '0, ADDR_TOP, 5'd1, '0));
        pending_ops.push_back(pack_op(OP_MEM_REG, '0, '0, '0, 12'h002, 5'd2, PUSH_OFFS));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd9, '0, '0, ADDR_TOP, 5'd1, '0));
        pending_ops.push_back(pack_op(OP_MEM_REG, REG_TOP, '0, '0, 12'hFF8, 5'd16, OFFS_MAX));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd10, '0, '0, 12'hFFC, 5'd16, '0));
        pending_ops.push_back(pack_op(OP_MEM_REG, '0, '0, '0, 12'h108, 5'd3, OFFS_MIN));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd11, '0, '0, 12'h100, 5'd1, '0));
        pending_ops.push_back(pack_op(OP_MEM_SET, '0, '0, '0, 12'h200, '0, '0));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd12, '0, '0, 12'h200, 5'd1, '0));
        pending_ops.push_back(pack_op(OP_REG_MEM, 4'd6, '0, '0, 12'hFFC, '0, '0));
        pending_ops.push_back(pack_op(OP_NOP, REG_TOP, REG_TOP, REG_TOP, ADDR_TOP,
                                      SIZE_TOP, PUSH_OFFS));
        pending_ops.push_back(pack_op(OPC_W'(OP_MEM_SET + 1), REG_TOP, '0, '0, '0,
                                      5'd4, '0));
        pending_ops.push_back(pack_op(OP_TOP, '0, REG_TOP, REG_TOP, ADDR_TOP, SIZE_TOP,
                                      OFFS_MIN));
        pending_ops.push_back(pack_op(OP_REG_OR, REG_TOP, REG_TOP, REG_TOP, ADDR_TOP,
                                      SIZE_TOP, OFFS_MIN));
        n_total = pending_ops.size() + N_RANDOM;

        // random: mostly single ops, some taint flow chains through memory
        while (pending_ops.size() < n_total) begin
            if ($urandom_range(0, 3) == 0) begin
                op    = random_op();
                span  = $urandom_range(1, 4);
                ra    = REG_W'($urandom());
                rb    = REG_W'($urandom());
                op.addr = HOT_BASE + ADDR_W'($urandom_range(0, 63));
                pending_ops.push_back(pack_op(($urandom_range(0, 3) == 0) ? OP_MEM_CLR
                                                                          : OP_MEM_SET,
                                              '0, '0, '0, op.addr, SIZE_IN_W'(span), '0));
                pending_ops.push_back(pack_op(OP_REG_MEM, ra, '0, '0,
                                              op.addr + ADDR_W'($urandom_range(0, span)),
                                              SIZE_IN_W'($urandom_range(1, 4)), '0));
                pending_ops.push_back(pack_op(OP_REG_OR, rb, ra, REG_W'($urandom()),
                                              '0, '0, '0));
                pending_ops.push_back(pack_op(OP_MEM_REG, rb, '0, '0, op.addr + ADDR_W'(4),
                                              SIZE_IN_W'(span), PUSH_OFFS));
            end else begin
                pending_ops.push_back(random_op());
            end
        end
        n_total = pending_ops.size();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total || expected_results.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
src/tpe_pkg.sv
src/tpe_ram.sv
src/tpe_front.sv
src/tpe_queue.sv
src/tpe_back.sv
src/taint_propagation_engine.sv
bench/taint_propagation_engine_tb.sv
